[hw/rtl/wpm_pkg.sv]
// Shared types and constants for the wildcard pattern matcher.
`default_nettype none

package wpm_pkg;

   // Request action codes.
   localparam logic [1:0] ACT_CLEAR   = 2'd0;
   localparam logic [1:0] ACT_APPEND  = 2'd1;
   localparam logic [1:0] ACT_TEXT    = 2'd2;
   localparam logic [1:0] ACT_RESTART = 2'd3;

   // Wildcard bytes.
   localparam logic [7:0] STAR_BYTE  = 8'h2A;
   localparam logic [7:0] QMARK_BYTE = 8'h3F;

   // Command from the request stage to the pattern store. Both strobes are
   // only raised in the cycle in which a request is processed.
   typedef struct packed {
      logic       clear;
      logic       append;
      logic [7:0] ch;
   } pat_cmd_type;

endpackage

`default_nettype wire

[hw/rtl/wpm_pattern_store.sv]
// Pattern byte registers, pattern length and per-position compare flags.
`default_nettype none

module wpm_pattern_store
   import wpm_pkg::*;
#(
   parameter int MAX_PATTERN = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire pat_cmd_type                        cmd,
   output logic [$clog2(MAX_PATTERN+1)-1:0]        count_eff,
   output logic                                    full,
   output logic [MAX_PATTERN-1:0]                  valid_vec,
   output logic [MAX_PATTERN-1:0]                  star_vec,
   output logic [MAX_PATTERN-1:0]                  hit_vec
);

   localparam int CNT_W = $clog2(MAX_PATTERN + 1);

   logic [7:0]       store_ff [MAX_PATTERN];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_append;
   logic [7:0]       byte_eff [MAX_PATTERN];

   // The flags describe the pattern as it stands after this command, so an
   // append is already visible to the row rebuild in the same cycle.
   always_comb begin
      full      = (count_ff == CNT_W'(MAX_PATTERN));
      do_append = cmd.append && !full;
      if (cmd.clear) begin
         count_in = '0;
      end else begin
         count_in = count_ff + CNT_W'(do_append);
      end
      count_eff = count_in;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (do_append && (count_ff == CNT_W'(i))) begin
            byte_eff[i] = cmd.ch;
         end else begin
            byte_eff[i] = store_ff[i];
         end
         valid_vec[i] = (CNT_W'(i) < count_in);
         star_vec[i]  = (byte_eff[i] == STAR_BYTE);
         hit_vec[i]   = star_vec[i] || (byte_eff[i] == QMARK_BYTE) ||
                        (byte_eff[i] == cmd.ch);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (do_append && (count_ff == CNT_W'(i))) begin
            store_ff[i] <= cmd.ch;
         end
      end
   end

endmodule

`default_nettype wire

[hw/rtl/wpm_row_update.sv]
// Prefix-match row update with a parallel-prefix star chain.
`default_nettype none

module wpm_row_update
   import wpm_pkg::*;
#(
   parameter int MAX_PATTERN = 32
) (
   input  wire logic [MAX_PATTERN:0]   old_row,
   input  wire logic [MAX_PATTERN-1:0] valid_vec,
   input  wire logic [MAX_PATTERN-1:0] star_vec,
   input  wire logic [MAX_PATTERN-1:0] hit_vec,
   input  wire logic                   rebuild,
   output logic      [MAX_PATTERN:0]   new_row
);

   localparam int ROW_W  = MAX_PATTERN + 1;
   localparam int LEVELS = $clog2(ROW_W);

   logic [ROW_W-1:0] gen;
   logic [ROW_W-1:0] prop;
   logic [ROW_W-1:0] g_lvl [LEVELS+1];
   logic [ROW_W-1:0] p_lvl [LEVELS+1];

   // Bit j is gen[j] or (prop[j] and bit j-1): a carry chain that a star
   // propagates, resolved in log2 levels.
   always_comb begin
      gen[0]  = rebuild;
      prop[0] = 1'b0;
      for (int j = 1; j < ROW_W; j++) begin
         prop[j] = valid_vec[j-1] && star_vec[j-1];
         gen[j]  = !rebuild && valid_vec[j-1] &&
                   ((star_vec[j-1] && old_row[j]) || (old_row[j-1] && hit_vec[j-1]));
      end
      g_lvl[0] = gen;
      p_lvl[0] = prop;
      for (int k = 0; k < LEVELS; k++) begin
         for (int j = 0; j < ROW_W; j++) begin
            if (j >= (1 << k)) begin
               g_lvl[k+1][j] = g_lvl[k][j] || (p_lvl[k][j] && g_lvl[k][j-(1<<k)]);
               p_lvl[k+1][j] = p_lvl[k][j] && p_lvl[k][j-(1<<k)];
            end else begin
               g_lvl[k+1][j] = g_lvl[k][j];
               p_lvl[k+1][j] = p_lvl[k][j];
            end
         end
      end
      new_row = g_lvl[LEVELS];
   end

endmodule

`default_nettype wire

[hw/rtl/wildcard_pattern_matcher.sv]
// Top level of the streaming wildcard pattern matcher.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_stall  req_action[1:0], req_ch[7:0]
//   rsp      out        rsp_valid / rsp_stall  rsp_matched, rsp_status
//
// An accepted request is held in the request register until the response
// register can load; the response register then shows its response, so the
// response can be taken from there.
// One request is accepted per cycle while the response side keeps up; the
// throughput is set by the combinational row update between the two registers.
// A stalled response holds the request register, and req_stall rises only when
// that register is full and cannot move on.
// Reset is synchronous and active high: the pattern becomes empty and the row
// holds only the empty-prefix bit. Pattern bytes are not cleared.
`default_nettype none

module wildcard_pattern_matcher
   import wpm_pkg::*;
#(
   parameter int MAX_PATTERN = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_action,
   input  wire logic [7:0] req_ch,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_matched,
   output logic            rsp_status
);

   localparam int CNT_W = $clog2(MAX_PATTERN + 1);
   localparam int ROW_W = MAX_PATTERN + 1;

   // Request register.
   logic       in_valid_ff;
   logic [1:0] in_action_ff;
   logic [7:0] in_ch_ff;

   // Response register.
   logic rsp_valid_ff;
   logic rsp_matched_ff;
   logic rsp_status_ff;

   // Prefix-match row: bit j is set when the text so far matches the first
   // j pattern bytes.
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;
   logic [ROW_W-1:0] row_upd;

   logic             rsp_adv;
   logic             fire;
   pat_cmd_type      cmd;
   logic [CNT_W-1:0] count_eff;
   logic             full;
   logic [MAX_PATTERN-1:0] valid_vec;
   logic [MAX_PATTERN-1:0] star_vec;
   logic [MAX_PATTERN-1:0] hit_vec;
   logic             rebuild;
   logic             drop;

   // The response register can load when it is empty or being taken.
   assign rsp_adv   = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && rsp_adv;
   assign req_stall = in_valid_ff && !rsp_adv;

   always_comb begin
      cmd.clear  = fire && (in_action_ff == ACT_CLEAR);
      cmd.append = fire && (in_action_ff == ACT_APPEND);
      cmd.ch     = in_ch_ff;
   end

   wpm_pattern_store #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .count_eff(count_eff),
      .full     (full),
      .valid_vec(valid_vec),
      .star_vec (star_vec),
      .hit_vec  (hit_vec)
   );

   // Appends and restarts rebuild the row for the empty text; a text byte
   // advances it.
   assign rebuild = (in_action_ff != ACT_TEXT);

   wpm_row_update #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_row (
      .old_row  (row_ff),
      .valid_vec(valid_vec),
      .star_vec (star_vec),
      .hit_vec  (hit_vec),
      .rebuild  (rebuild),
      .new_row  (row_upd)
   );

   // A full pattern drops the appended byte and leaves the text untouched.
   assign drop = (in_action_ff == ACT_APPEND) && full;

   always_comb begin
      row_in = row_ff;
      if (fire) begin
         case (in_action_ff)
            ACT_CLEAR: begin
               row_in = ROW_W'(1);
            end
            ACT_APPEND: begin
               if (!full) begin
                  row_in = row_upd;
               end
            end
            ACT_TEXT, ACT_RESTART: begin
               row_in = row_upd;
            end
            default: begin
               row_in = row_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= ROW_W'(1);
      end else begin
         row_ff <= row_in;
      end
   end

   // Request register loads whenever it is free to move on.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_action_ff <= req_action;
         in_ch_ff     <= req_ch;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_adv) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_matched_ff <= row_in[count_eff];
         rsp_status_ff  <= drop;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_matched = rsp_matched_ff;
   assign rsp_status  = rsp_status_ff;

   // The row never marks a prefix longer than the stored pattern.
   a_row_within_count: assert property (@(posedge clock) disable iff (reset)
      ((row_ff >> u_store.count_ff) >> 1) == '0)
      else $error("prefix row has bits above the pattern length");

   // The pattern length stays within its capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      u_store.count_ff <= CNT_W'(MAX_PATTERN))
      else $error("pattern length exceeds capacity");

   // A waiting drop response implies the pattern is still full.
   a_status_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> full)
      else $error("drop reported while the pattern has room");

   // A waiting response agrees with the state it was computed from.
   a_match_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_matched_ff == row_ff[u_store.count_ff]))
      else $error("response does not match the stored row");

   // The row only changes when a request is processed.
   a_row_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(row_ff))
      else $error("row changed without a request");

endmodule

`default_nettype wire
